// File: sv/hsi_to_rgb_converter_unit_defines.svh
// ----------------------------------------------------------------------------
// HSI to RGB converter: assertion macros
// Shorthand for the concurrent checks on the converter's ports.
// ----------------------------------------------------------------------------
`ifndef HSI_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSI_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSI_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSI_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define HSI_ASSERT_NEXT_ALWAYS(lbl, clk_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hsi_pkg.sv
// ----------------------------------------------------------------------------
// HSI to RGB converter package
// Field widths, sector codes, stage control type and the elaboration-time
// functions that build the hue ratio table.
// ----------------------------------------------------------------------------
`default_nettype none

package hsi_pkg;

  localparam int RATIO_FRAC_BITS_DEF = 14;

  localparam int HueW      = 10;
  localparam int SatW      = 10;
  localparam int IntW      = 10;
  localparam int ChanW     = 8;
  localparam int UnitQ8    = 256;
  localparam int LevelW    = 9;    // clamped Q.8 value, 0..256
  localparam int SectorDeg = 120;
  localparam int DegW      = 7;
  localparam int TurnsMax  = 8;    // sector starts above zero that fit in the hue field
  localparam int TurnW     = 4;
  localparam int NumChan   = 3;
  localparam int ChA       = 0;
  localparam int ChB       = 1;
  localparam int ChC       = 2;
  localparam int ChanMax   = 255;

  // Division by three of the scaled level: (t * 683) >> 11 is exact below 2048.
  localparam int ScaleW      = 11;
  localparam int Recip3      = 683;
  localparam int Recip3W     = 10;
  localparam int Recip3Shift = 11;
  localparam int QuoW        = ScaleW + Recip3W - Recip3Shift;

  localparam int CosFrac  = 28;
  localparam int CosTerms = 12;
  localparam int HalfTurn = 180;
  localparam int QuarterTurn = 90;
  localparam int SixthTurn   = 60;
  localparam int DegToRadDiv = 720;
  localparam longint unsigned PiQ30 = 64'd3373259426;

  typedef enum logic [1:0] {
    SEC_0 = 2'd0,
    SEC_1 = 2'd1,
    SEC_2 = 2'd2
  } sector_t;

  typedef struct packed {
    logic en_a;
    logic en_b;
  } stage_ctl_t;

  // Restoring division, only evaluated while the design elaborates.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    int b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Cosine of a whole degree in Q.28 by a truncated Taylor series.
  function automatic longint cos_q28(input int deg);
    int unsigned     a;
    bit              neg;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    int              k;
    a   = (deg < 0) ? int'(-deg) : deg;
    neg = 1'b0;
    if (a > QuarterTurn) begin
      a   = HalfTurn - a;
      neg = 1'b1;
    end
    x    = udiv64(64'(a) * PiQ30, 64'(DegToRadDiv));
    x2   = (x * x) >> CosFrac;
    term = 64'd1 << CosFrac;
    sum  = longint'(term);
    for (k = 1; k <= CosTerms; k++) begin
      term = (term * x2) >> CosFrac;
      term = udiv64(term, 64'((2 * k - 1) * (2 * k)));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return neg ? -sum : sum;
  endfunction

  // cos(d)/cos(60-d) in Q.frac, rounded half away from zero.
  function automatic longint ratio_q(input int d, input int frac);
    longint ca;
    longint cb;
    longint num;
    longint q;
    ca  = cos_q28(d);
    cb  = cos_q28(SixthTurn - d);
    num = ca <<< frac;
    if (cb < 1) begin
      cb = 1;
    end
    if (num >= 0) begin
      q = longint'(udiv64(64'(num + (cb >>> 1)), 64'(cb)));
    end else begin
      q = -longint'(udiv64(64'(-num + (cb >>> 1)), 64'(cb)));
    end
    return q;
  endfunction

  // Level divided by three, saturated to the channel range.
  function automatic logic [ChanW-1:0] div3_sat(input logic [ScaleW-1:0] t);
    logic [ScaleW+Recip3W-1:0] prod;
    logic [QuoW-1:0]           quo;
    prod = (ScaleW+Recip3W)'(t) * (ScaleW+Recip3W)'(Recip3);
    quo  = prod[ScaleW+Recip3W-1:Recip3Shift];
    return (quo > QuoW'(ChanMax)) ? ChanW'(ChanMax) : quo[ChanW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/hsi_in_if.sv
// ----------------------------------------------------------------------------
// HSI input channel
// Valid/ready channel carrying one pixel as hue, saturation and intensity.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsi_in_if;
  import hsi_pkg::*;

  logic            valid;
  logic            ready;
  logic [HueW-1:0] hue_degrees;
  logic [SatW-1:0] saturation;
  logic [IntW-1:0] intensity;

  modport source (output valid, hue_degrees, saturation, intensity, input ready);
  modport sink   (input valid, hue_degrees, saturation, intensity, output ready);
endinterface

`default_nettype wire

// File: sv/hsi_out_if.sv
// ----------------------------------------------------------------------------
// RGB output channel
// Valid/ready channel carrying one pixel as 8-bit red, green and blue.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsi_out_if;
  import hsi_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// File: sv/hsi_sector.sv
// ----------------------------------------------------------------------------
// HSI sector stage
// Reduces the hue to a 120-degree sector and offset, and clamps saturation
// and intensity to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_sector (
  input  logic                        clk,
  input  logic                        en,
  input  logic [hsi_pkg::HueW-1:0]    hue,
  input  logic [hsi_pkg::SatW-1:0]    sat,
  input  logic [hsi_pkg::IntW-1:0]    inten,
  output hsi_pkg::sector_t            sec_r,
  output logic [hsi_pkg::DegW-1:0]    deg_r,
  output logic [hsi_pkg::LevelW-1:0]  sat_r,
  output logic [hsi_pkg::LevelW-1:0]  inten_r
);
  import hsi_pkg::*;

  logic [TurnW-1:0]  turn;
  logic [HueW-1:0]   base;
  sector_t           sec_nxt;
  logic [DegW-1:0]   deg_nxt;
  logic [LevelW-1:0] sat_nxt;
  logic [LevelW-1:0] inten_nxt;

  // Count the 120-degree boundaries at or below the hue; the modulo 360
  // folds into the sector code.
  always_comb begin
    turn = '0;
    for (int j = 1; j <= TurnsMax; j++) begin
      if (hue >= HueW'(j * SectorDeg)) begin
        turn = turn + TurnW'(1);
      end
    end
  end

  always_comb begin
    case (turn)
      4'd0, 4'd3, 4'd6: sec_nxt = SEC_0;
      4'd1, 4'd4, 4'd7: sec_nxt = SEC_1;
      4'd2, 4'd5, 4'd8: sec_nxt = SEC_2;
      default:          sec_nxt = SEC_0;
    endcase
  end

  assign base      = HueW'(turn) * HueW'(SectorDeg);
  assign deg_nxt   = DegW'(hue - base);
  assign sat_nxt   = (sat > SatW'(UnitQ8)) ? LevelW'(UnitQ8) : sat[LevelW-1:0];
  assign inten_nxt = (inten > IntW'(UnitQ8)) ? LevelW'(UnitQ8) : inten[LevelW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sec_r   <= sec_nxt;
      deg_r   <= deg_nxt;
      sat_r   <= sat_nxt;
      inten_r <= inten_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/hsi_bracket.sv
// ----------------------------------------------------------------------------
// HSI bracket stages
// Looks up the hue ratio, then forms the three bracket terms
// 1+S*R, 1+S*(1-R) and 1-S in Q.(8+frac), clamped at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_bracket #(
  parameter int RATIO_FRAC_BITS = hsi_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  hsi_pkg::stage_ctl_t               ctl,
  input  hsi_pkg::sector_t                  sec,
  input  logic [hsi_pkg::DegW-1:0]          deg,
  input  logic [hsi_pkg::LevelW-1:0]        sat,
  input  logic [hsi_pkg::LevelW-1:0]        inten,
  output logic [RATIO_FRAC_BITS+9:0]        br_r [hsi_pkg::NumChan],
  output logic [hsi_pkg::LevelW-1:0]        inten_r,
  output hsi_pkg::sector_t                  sec_r
);
  import hsi_pkg::*;

  localparam int QW  = RATIO_FRAC_BITS + 3;
  localparam int PRW = RATIO_FRAC_BITS + 13;
  localparam int BRW = RATIO_FRAC_BITS + 10;
  localparam logic signed [PRW-1:0] One  = PRW'(longint'(1) << RATIO_FRAC_BITS);
  localparam logic signed [PRW-1:0] Base = PRW'(longint'(UnitQ8) << RATIO_FRAC_BITS);

  logic signed [QW-1:0]  ratio_tab [SectorDeg];
  logic signed [QW-1:0]  q_r;
  logic [LevelW-1:0]     sat_a_r;
  logic [LevelW-1:0]     inten_a_r;
  sector_t               sec_a_r;

  logic signed [PRW-1:0] s_x;
  logic signed [PRW-1:0] q_x;
  logic signed [PRW-1:0] omq;
  logic signed [PRW-1:0] sum [NumChan];
  logic [BRW-1:0]        br_nxt [NumChan];

  // Ratio table, fixed at elaboration for the chosen fraction width.
  for (genvar g = 0; g < SectorDeg; g++) begin : g_tab
    localparam longint Val = ratio_q(g, RATIO_FRAC_BITS);
    assign ratio_tab[g] = QW'(Val);
  end

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      q_r       <= ratio_tab[deg];
      sat_a_r   <= sat;
      inten_a_r <= inten;
      sec_a_r   <= sec;
    end
  end

  assign s_x = PRW'({1'b0, sat_a_r});
  assign q_x = PRW'(q_r);
  assign omq = One - q_x;

  assign sum[ChA] = Base + s_x * q_x;
  assign sum[ChB] = Base + s_x * omq;
  assign sum[ChC] = (PRW'(UnitQ8) - s_x) <<< RATIO_FRAC_BITS;

  // Table rounding can drive a bracket slightly negative; that reads as zero.
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      br_nxt[c] = sum[c][PRW-1] ? '0 : sum[c][BRW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      br_r    <= br_nxt;
      inten_r <= inten_a_r;
      sec_r   <= sec_a_r;
    end
  end

endmodule

`default_nettype wire

// File: sv/hsi_scale.sv
// ----------------------------------------------------------------------------
// HSI scale stages
// Multiplies each bracket by the intensity, then scales by 255 and drops the
// fraction, leaving a level still to be divided by three.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_scale #(
  parameter int RATIO_FRAC_BITS = hsi_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  hsi_pkg::stage_ctl_t               ctl,
  input  logic [RATIO_FRAC_BITS+9:0]        br [hsi_pkg::NumChan],
  input  logic [hsi_pkg::LevelW-1:0]        inten,
  input  hsi_pkg::sector_t                  sec,
  output logic [hsi_pkg::ScaleW-1:0]        lvl_r [hsi_pkg::NumChan],
  output hsi_pkg::sector_t                  sec_r
);
  import hsi_pkg::*;

  localparam int BRW    = RATIO_FRAC_BITS + 10;
  localparam int PW     = BRW + LevelW;
  localparam int TShift = RATIO_FRAC_BITS + 16;
  localparam int WW     = TShift + ScaleW;

  logic [PW-1:0]     prod_r [NumChan];
  sector_t           sec_a_r;
  logic [WW-1:0]     wide [NumChan];
  logic [ScaleW-1:0] lvl_nxt [NumChan];

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      for (int c = 0; c < NumChan; c++) begin
        prod_r[c] <= PW'(inten) * PW'(br[c]);
      end
      sec_a_r <= sec;
    end
  end

  // 255 * p as (p << 8) - p; the top bits are the level before the divide by three.
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      wide[c]    = (WW'(prod_r[c]) << ChanW) - WW'(prod_r[c]);
      lvl_nxt[c] = wide[c][TShift +: ScaleW];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      lvl_r <= lvl_nxt;
      sec_r <= sec_a_r;
    end
  end

endmodule

`default_nettype wire

// File: sv/hsi_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// HSI to RGB converter
// Converts one pixel from hue, saturation and intensity to 8-bit RGB in a
// six-stage pipeline.
//
//   Channel   Direction  Payload
//   in_ch     input      hue_degrees[9:0], saturation[9:0], intensity[9:0]
//   out_ch    output     red[7:0], green[7:0], blue[7:0]
//
// One item enters per cycle while the output is not stalled; each item passes
// through the six register stages in order: sector, ratio lookup, bracket,
// intensity multiply, scale, output.
// Each stage holds its item only while the next stage is full and blocked,
// so empty stages fill up behind a stalled output without losing items.
// Reset is synchronous and clears only the stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_to_rgb_converter_unit #(
  parameter int RATIO_FRAC_BITS = hsi_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hsi_in_if.sink     in_ch,
  hsi_out_if.source  out_ch
);
  import hsi_pkg::*;

  localparam int BRW       = RATIO_FRAC_BITS + 10;
  localparam int NumStages = 6;
  localparam int StSector  = 0;
  localparam int StRatio   = 1;
  localparam int StBracket = 2;
  localparam int StMult    = 3;
  localparam int StScale   = 4;
  localparam int StOut     = 5;

  logic [NumStages-1:0] vld_r;
  logic [NumStages-1:0] vld_nxt;
  logic [NumStages-1:0] en;

  sector_t           s1_sec;
  logic [DegW-1:0]   s1_deg;
  logic [LevelW-1:0] s1_sat;
  logic [LevelW-1:0] s1_inten;

  logic [BRW-1:0]    s3_br [NumChan];
  logic [LevelW-1:0] s3_inten;
  sector_t           s3_sec;

  logic [ScaleW-1:0] s5_lvl [NumChan];
  sector_t           s5_sec;

  stage_ctl_t        brk_ctl;
  stage_ctl_t        scl_ctl;

  logic [ChanW-1:0]  lvl_a;
  logic [ChanW-1:0]  lvl_b;
  logic [ChanW-1:0]  lvl_c;
  logic [ChanW-1:0]  red_nxt;
  logic [ChanW-1:0]  green_nxt;
  logic [ChanW-1:0]  blue_nxt;
  logic [ChanW-1:0]  red_r;
  logic [ChanW-1:0]  green_r;
  logic [ChanW-1:0]  blue_r;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[StOut] = ~vld_r[StOut] | out_ch.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = ~vld_r[k] | en[k+1];
    end
  end

  always_comb begin
    vld_nxt[StSector] = in_ch.valid;
    for (int k = 1; k < NumStages; k++) begin
      vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  assign in_ch.ready = en[StSector];
  assign brk_ctl     = '{en_a: en[StRatio], en_b: en[StBracket]};
  assign scl_ctl     = '{en_a: en[StMult], en_b: en[StScale]};

  hsi_sector u_sector (
    .clk     (clk),
    .en      (en[StSector]),
    .hue     (in_ch.hue_degrees),
    .sat     (in_ch.saturation),
    .inten   (in_ch.intensity),
    .sec_r   (s1_sec),
    .deg_r   (s1_deg),
    .sat_r   (s1_sat),
    .inten_r (s1_inten)
  );

  hsi_bracket #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_bracket (
    .clk     (clk),
    .ctl     (brk_ctl),
    .sec     (s1_sec),
    .deg     (s1_deg),
    .sat     (s1_sat),
    .inten   (s1_inten),
    .br_r    (s3_br),
    .inten_r (s3_inten),
    .sec_r   (s3_sec)
  );

  hsi_scale #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_scale (
    .clk   (clk),
    .ctl   (scl_ctl),
    .br    (s3_br),
    .inten (s3_inten),
    .sec   (s3_sec),
    .lvl_r (s5_lvl),
    .sec_r (s5_sec)
  );

  assign lvl_a = div3_sat(s5_lvl[ChA]);
  assign lvl_b = div3_sat(s5_lvl[ChB]);
  assign lvl_c = div3_sat(s5_lvl[ChC]);

  always_comb begin
    case (s5_sec)
      SEC_0: begin
        red_nxt   = lvl_a;
        green_nxt = lvl_b;
        blue_nxt  = lvl_c;
      end
      SEC_1: begin
        red_nxt   = lvl_c;
        green_nxt = lvl_a;
        blue_nxt  = lvl_b;
      end
      SEC_2: begin
        red_nxt   = lvl_b;
        green_nxt = lvl_c;
        blue_nxt  = lvl_a;
      end
      default: begin
        red_nxt   = lvl_a;
        green_nxt = lvl_b;
        blue_nxt  = lvl_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[StOut]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_ch.valid = vld_r[StOut];
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

endmodule

`default_nettype wire

// File: sv/hsi_to_rgb_converter_unit_chk.sv
// ----------------------------------------------------------------------------
// HSI to RGB converter port checker
// Watches the converter's ports for reset behavior, flow control and held
// results, and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsi_to_rgb_converter_unit_defines.svh"

module hsi_to_rgb_converter_unit_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [hsi_pkg::ChanW-1:0] red,
  input logic [hsi_pkg::ChanW-1:0] green,
  input logic [hsi_pkg::ChanW-1:0] blue
);

  // The pipeline is empty after reset: nothing to deliver, room to accept.
  `HSI_ASSERT_NEXT_ALWAYS(a_no_result_after_reset, clk, !rst_n, !out_valid, "result valid right after reset")
  `HSI_ASSERT_NEXT_ALWAYS(a_ready_after_reset, clk, !rst_n, in_ready, "input not ready after reset")

  // A taken output frees every stage, so an offered item must be accepted.
  `HSI_ASSERT_NOW(a_ready_when_drained, clk, rst_n, in_valid && out_ready, in_ready, "input blocked while output drains")

  `HSI_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue), "stalled result changed")

endmodule

bind hsi_to_rgb_converter_unit hsi_to_rgb_converter_unit_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red       (out_ch.red),
  .green     (out_ch.green),
  .blue      (out_ch.blue)
);

`default_nettype wire
